// File: src/ialu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_pkg: shared types and constants of the 64-bit integer ALU
// Opcodes, status codes, payload structs and the front-to-back item.
// ----------------------------------------------------------------------------
package ialu_pkg;

	localparam int DataWidth = 64;
	localparam int ShWidth = $clog2(DataWidth);
	localparam int QDepth = 4;
	localparam int QAw = $clog2(QDepth);

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
		OP_POW = 5'd5, OP_EQ = 5'd6, OP_NE = 5'd7, OP_GT = 5'd8, OP_GE = 5'd9,
		OP_LT = 5'd10, OP_LE = 5'd11, OP_AND = 5'd12, OP_OR = 5'd13, OP_XOR = 5'd14,
		OP_SHL = 5'd15, OP_SHR = 5'd16, OP_INC = 5'd17, OP_DEC = 5'd18,
		OP_NOT = 5'd19, OP_LNOT = 5'd20, OP_LTEST = 5'd21
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_BADOP = 2'd2
	} status_t;

	// operation classes picked by the front end
	typedef enum logic [1:0] {
		CL_SIMPLE = 2'd0, CL_MUL = 2'd1, CL_DIV = 2'd2, CL_POW = 2'd3
	} class_t;

	typedef struct packed {
		logic [4:0] opcode;
		logic [63:0] left_value;
		logic [63:0] right_value;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_value;
		logic [1:0] status;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		class_t cls;
		logic rem;
		logic [DataWidth-1:0] a;
		logic [DataWidth-1:0] b;
		logic [DataWidth-1:0] simple;
		status_t status;
	} work_t;

endpackage
`default_nettype wire

// File: src/ialu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_front: operand decode and combinational operations
// Classifies each item and computes every simple-class result up front.
// ----------------------------------------------------------------------------
module ialu_front (
	input wire ialu_pkg::in_item_t item,
	output ialu_pkg::work_t work
);
	localparam int W = ialu_pkg::DataWidth;

	logic [W-1:0] a, b, r;
	logic big_sh;

	always_comb begin
		a = item.left_value[W-1:0];
		b = item.right_value[W-1:0];
		big_sh = (b >= W'(W));
		r = '0;
		work.cls = ialu_pkg::CL_SIMPLE;
		work.rem = 1'b0;
		work.status = ialu_pkg::ST_OK;
		unique case (item.opcode)
			ialu_pkg::OP_ADD: r = a + b;
			ialu_pkg::OP_SUB: r = a - b;
			ialu_pkg::OP_MUL: work.cls = ialu_pkg::CL_MUL;
			ialu_pkg::OP_DIV, ialu_pkg::OP_MOD: begin
				work.rem = (item.opcode == ialu_pkg::OP_MOD);
				if (b == '0)
					work.status = ialu_pkg::ST_DIV0;
				else
					work.cls = ialu_pkg::CL_DIV;
			end
			ialu_pkg::OP_POW: work.cls = ialu_pkg::CL_POW;
			ialu_pkg::OP_EQ: r = {{(W-1){1'b0}}, a == b};
			ialu_pkg::OP_NE: r = {{(W-1){1'b0}}, a != b};
			ialu_pkg::OP_GT: r = {{(W-1){1'b0}}, a > b};
			ialu_pkg::OP_GE: r = {{(W-1){1'b0}}, a >= b};
			ialu_pkg::OP_LT: r = {{(W-1){1'b0}}, a < b};
			ialu_pkg::OP_LE: r = {{(W-1){1'b0}}, a <= b};
			ialu_pkg::OP_AND: r = a & b;
			ialu_pkg::OP_OR: r = a | b;
			ialu_pkg::OP_XOR: r = a ^ b;
			ialu_pkg::OP_SHL: r = big_sh ? '0 : a << b[ialu_pkg::ShWidth-1:0];
			ialu_pkg::OP_SHR: r = big_sh ? '0 : a >> b[ialu_pkg::ShWidth-1:0];
			ialu_pkg::OP_INC: r = a + 1'b1;
			ialu_pkg::OP_DEC: r = a - 1'b1;
			ialu_pkg::OP_NOT: r = ~a;
			ialu_pkg::OP_LNOT: r = {{(W-1){1'b0}}, a == '0};
			ialu_pkg::OP_LTEST: r = {{(W-1){1'b0}}, a != '0};
			default: work.status = ialu_pkg::ST_BADOP;
		endcase
		work.a = a;
		work.b = b;
		work.simple = r;
	end

endmodule
`default_nettype wire

// File: src/ialu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_queue: short queue between front and back ends
// Register-based FIFO holding classified work items.
// ----------------------------------------------------------------------------
module ialu_queue (
	input wire clk,
	input wire arst_n,
	input wire push,
	input wire ialu_pkg::work_t push_data,
	output logic full,
	input wire pop,
	output ialu_pkg::work_t pop_data,
	output logic empty
);
	localparam int Aw = ialu_pkg::QAw;

	ialu_pkg::work_t mem_q [ialu_pkg::QDepth];
	logic [Aw-1:0] wr_q, rd_q;
	logic [Aw:0] cnt_q;

	assign full = (cnt_q == (Aw+1)'(ialu_pkg::QDepth));
	assign empty = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= wr_q + 1'b1;
			if (pop && !empty)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (Aw+1)'(push && !full) - (Aw+1)'(pop && !empty);
		end
	end

endmodule
`default_nettype wire

// File: src/ialu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_back: multi-cycle execution unit
// Multiply in 32x32 partial products, radix-2 divide, square-and-multiply
// power. One item at a time; simple items pass straight to the output state.
// ----------------------------------------------------------------------------
module ialu_back (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire ialu_pkg::work_t in_work,
	output logic in_ready,
	output logic out_valid,
	output ialu_pkg::out_item_t out_item,
	input wire out_ready
);
	localparam int W = ialu_pkg::DataWidth;
	localparam int Cw = $clog2(W + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_MUL = 6'b000010, S_DIV = 6'b000100,
		S_PSTEP = 6'b001000, S_PMUL = 6'b010000, S_OUT = 6'b100000
	} state_t;

	// multiply job: x*y low W bits, four 32x32 products one per cycle
	state_t state_q;
	logic [W-1:0] mx_q, my_q, macc_q;
	logic [1:0] mph_q;
	logic [W-1:0] rem_q, quo_q, dvs_q;
	logic [Cw-1:0] cnt_q;
	logic rem_sel_q;
	logic [W-1:0] acc_q, sq_q, exp_q;
	logic pmul_sq_q;
	logic [W-1:0] res_q;
	logic [1:0] st_q;
	logic [63:0] mx64, my64, pprod_shift;
	logic [31:0] pa, pb;
	logic [63:0] pprod;
	logic [W:0] trial;
	logic [W-1:0] rsh;
	logic take;

	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign take = in_valid && in_ready;
	assign out_valid = (state_q == S_OUT);
	assign out_item.result_value = 64'(res_q);
	assign out_item.status = st_q;

	always_comb begin
		mx64 = 64'(mx_q);
		my64 = 64'(my_q);
		pa = mph_q[1] ? mx64[63:32] : mx64[31:0];
		pb = mph_q[0] ? my64[63:32] : my64[31:0];
		pprod = 64'(pa) * 64'(pb);
		unique case (mph_q)
			2'd0: pprod_shift = pprod;
			2'd1, 2'd2: pprod_shift = pprod << 32;
			default: pprod_shift = '0;
		endcase
		rsh = {rem_q[W-2:0], quo_q[W-1]};
		trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE, S_OUT: begin
					if (take) begin
						unique case (in_work.cls)
							ialu_pkg::CL_MUL: state_q <= S_MUL;
							ialu_pkg::CL_DIV: state_q <= S_DIV;
							ialu_pkg::CL_POW: state_q <= (in_work.b == '0) ? S_OUT : S_PSTEP;
							default: state_q <= S_OUT;
						endcase
					end else if (state_q == S_OUT && out_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_MUL: if (mph_q == 2'd3) state_q <= S_OUT;
				S_DIV: if (cnt_q == Cw'(1)) state_q <= S_OUT;
				S_PSTEP: state_q <= S_PMUL;
				S_PMUL: begin
					if (mph_q == 2'd3) begin
						if (pmul_sq_q && exp_q[W-1:1] == '0) state_q <= S_OUT;
						else if (pmul_sq_q) state_q <= S_PSTEP;
						else state_q <= S_PMUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= (in_work.cls == ialu_pkg::CL_POW) ? {{(W-1){1'b0}}, 1'b1}
				: in_work.simple;
			st_q <= in_work.status;
			mx_q <= in_work.a;
			my_q <= in_work.b;
			mph_q <= 2'd0;
			macc_q <= '0;
			rem_q <= '0;
			quo_q <= in_work.a;
			dvs_q <= in_work.b;
			rem_sel_q <= in_work.rem;
			cnt_q <= Cw'(W);
			acc_q <= {{(W-1){1'b0}}, 1'b1};
			sq_q <= in_work.a;
			exp_q <= in_work.b;
		end else begin
			unique case (state_q)
				S_MUL: begin
					mph_q <= mph_q + 1'b1;
					macc_q <= macc_q + W'(pprod_shift);
					if (mph_q == 2'd3)
						res_q <= macc_q + W'(pprod_shift);
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (!trial[W]) begin
						rem_q <= trial[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[W-2:0], 1'b0};
					end
					if (cnt_q == Cw'(1))
						res_q <= rem_sel_q ? (trial[W] ? rsh : trial[W-1:0])
							: {quo_q[W-2:0], !trial[W]};
				end
				S_PSTEP: begin
					// first multiply acc*sq if bit set, else go straight to sq*sq
					mph_q <= 2'd0;
					macc_q <= '0;
					pmul_sq_q <= !exp_q[0];
					mx_q <= exp_q[0] ? acc_q : sq_q;
					my_q <= sq_q;
				end
				S_PMUL: begin
					mph_q <= mph_q + 1'b1;
					if (mph_q == 2'd3) begin
						macc_q <= '0;
						if (!pmul_sq_q) begin
							acc_q <= macc_q + W'(pprod_shift);
							res_q <= macc_q + W'(pprod_shift);
							pmul_sq_q <= 1'b1;
							mx_q <= sq_q;
							my_q <= sq_q;
						end else begin
							sq_q <= macc_q + W'(pprod_shift);
							exp_q <= exp_q >> 1;
							res_q <= acc_q;
						end
					end else begin
						macc_q <= macc_q + W'(pprod_shift);
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: src/integer_alu_64_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_alu_64_top: 64-bit integer ALU with queue interfaces
// Input channel: push/full carrying in_item; result channel: pop/empty
// carrying out_item, one result per transfer in arrival order.
// The front end decodes each item and computes add, sub, compares, logic,
// shifts and unary ops in the accept cycle; items enter a 4-deep queue.
// The back end takes one item at a time: simple ops reach the output state in
// the cycle after leaving the queue and stream one per cycle while popped.
// Multiply runs four 32x32 partial products, divide and modulo one quotient
// bit a cycle, power a step state per exponent bit, then acc*sq if the bit is
// set and sq*sq, both through the same multiplier.
// The back-end output register holds a result until popped; a stalled
// receiver fills the queue and then raises full.
// Reset clears the queue and the back-end control; no result is pending.
// ----------------------------------------------------------------------------
module integer_alu_64_top (
	input wire clk,
	input wire arst_n,
	input wire push,
	input wire ialu_pkg::in_item_t in_item,
	output logic full,
	output logic empty,
	input wire pop,
	output ialu_pkg::out_item_t out_item
);
	ialu_pkg::work_t front_work, q_work;
	logic q_empty, back_ready, back_valid;

	ialu_front u_front (.item(in_item), .work(front_work));

	ialu_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(front_work), .full(full),
		.pop(back_ready), .pop_data(q_work), .empty(q_empty)
	);

	ialu_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(!q_empty), .in_work(q_work), .in_ready(back_ready),
		.out_valid(back_valid), .out_item(out_item), .out_ready(pop)
	);

	assign empty = !back_valid;

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_item.status != 2'd3)
		else $error("bad status");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.status != ialu_pkg::ST_OK) |-> out_item.result_value == '0)
		else $error("error result not zero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_item)))
		else $error("result changed while stalled");

endmodule
`default_nettype wire

// File: verif/integer_alu_64_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_alu_64_top_tb: self-checking bench for the 64-bit integer ALU
// Directed corner items, then random items under varying sender and
// receiver idling and a long receiver hold-off. Every result transfer is
// checked in order against an in-bench calculation of the ALU.
// ----------------------------------------------------------------------------
module integer_alu_64_top_tb;

	localparam int StallLimit = 20000;

	logic clk;
	logic arst_n;
	logic push;
	logic pop;
	logic full;
	logic empty;
	ialu_pkg::in_item_t in_item;
	ialu_pkg::out_item_t out_item;

	ialu_pkg::out_item_t alu_results[$];
	int fail_count;
	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold;
	int quiet_cycles;

	integer_alu_64_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.in_item(in_item),
		.full(full),
		.empty(empty),
		.pop(pop),
		.out_item(out_item)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] wrap_power(logic [63:0] base, logic [63:0] expo);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1;
		sq = base;
		while (expo != 64'd0) begin
			if (expo[0]) acc = acc * sq;
			sq = sq * sq;
			expo = expo >> 1;
		end
		return acc;
	endfunction

	function automatic ialu_pkg::out_item_t alu_calc(ialu_pkg::in_item_t it);
		ialu_pkg::out_item_t r;
		logic [63:0] a;
		logic [63:0] b;
		a = it.left_value;
		b = it.right_value;
		r.result_value = 64'd0;
		r.status = ialu_pkg::ST_OK;
		case (it.opcode)
			ialu_pkg::OP_ADD: r.result_value = a + b;
			ialu_pkg::OP_SUB: r.result_value = a - b;
			ialu_pkg::OP_MUL: r.result_value = a * b;
			ialu_pkg::OP_DIV:
				if (b == 0) r.status = ialu_pkg::ST_DIV0; else r.result_value = a / b;
			ialu_pkg::OP_MOD:
				if (b == 0) r.status = ialu_pkg::ST_DIV0; else r.result_value = a % b;
			ialu_pkg::OP_POW: r.result_value = wrap_power(a, b);
			ialu_pkg::OP_EQ: r.result_value = {63'd0, a == b};
			ialu_pkg::OP_NE: r.result_value = {63'd0, a != b};
			ialu_pkg::OP_GT: r.result_value = {63'd0, a > b};
			ialu_pkg::OP_GE: r.result_value = {63'd0, a >= b};
			ialu_pkg::OP_LT: r.result_value = {63'd0, a < b};
			ialu_pkg::OP_LE: r.result_value = {63'd0, a <= b};
			ialu_pkg::OP_AND: r.result_value = a & b;
			ialu_pkg::OP_OR: r.result_value = a | b;
			ialu_pkg::OP_XOR: r.result_value = a ^ b;
			ialu_pkg::OP_SHL: r.result_value = (b >= 64) ? 64'd0 : a << b[5:0];
			ialu_pkg::OP_SHR: r.result_value = (b >= 64) ? 64'd0 : a >> b[5:0];
			ialu_pkg::OP_INC: r.result_value = a + 64'd1;
			ialu_pkg::OP_DEC: r.result_value = a - 64'd1;
			ialu_pkg::OP_NOT: r.result_value = ~a;
			ialu_pkg::OP_LNOT: r.result_value = {63'd0, a == 0};
			ialu_pkg::OP_LTEST: r.result_value = {63'd0, a != 0};
			default: r.status = ialu_pkg::ST_BADOP;
		endcase
		return r;
	endfunction

	// one transfer on the input side, then an optional random gap
	task automatic send_item(logic [4:0] op, logic [63:0] a, logic [63:0] b);
		ialu_pkg::in_item_t it;
		int gap;
		it.opcode = op;
		it.left_value = a;
		it.right_value = b;
		push <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (full);
		alu_results.push_back(alu_calc(it));
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 8) gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		push <= 1'b0;
		@(posedge clk);
		while (alu_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_operand();
		case ($urandom_range(5))
			0: return 64'd0;
			1: return '1;
			2: return 64'd1 << $urandom_range(63);
			3: return 64'($urandom_range(255));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		ialu_pkg::out_item_t exp_item;
		if (!arst_n) begin
			pop <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			if (pop && !empty) begin
				if (alu_results.size() == 0) begin
					$error("unexpected result %h", out_item);
					fail_count++;
				end else begin
					exp_item = alu_results.pop_front();
					if (out_item.result_value !== exp_item.result_value) begin
						$error("result_value exp %h got %h", exp_item.result_value,
							out_item.result_value);
						fail_count++;
					end
					if (out_item.status !== exp_item.status) begin
						$error("status exp %0d got %0d", exp_item.status, out_item.status);
						fail_count++;
					end
				end
			end
			if ((push && !full) || (pop && !empty) ||
					(!push && alu_results.size() == 0))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("FAILURE");
				$finish;
			end
			if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				pop <= 1'b0;
			end else
				pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic test_directed();
		send_item(ialu_pkg::OP_ADD, '1, 64'd1);
		send_item(ialu_pkg::OP_SUB, 64'd0, 64'd1);
		send_item(ialu_pkg::OP_MUL, '1, '1);
		send_item(ialu_pkg::OP_DIV, '1, 64'd3);
		send_item(ialu_pkg::OP_DIV, 64'd5, 64'd0);
		send_item(ialu_pkg::OP_MOD, '1, 64'd10);
		send_item(ialu_pkg::OP_MOD, 64'd7, 64'd0);
		send_item(ialu_pkg::OP_POW, 64'd0, 64'd0);
		send_item(ialu_pkg::OP_POW, 64'd3, '1);
		send_item(ialu_pkg::OP_POW, 64'd3, 64'd5);
		send_item(ialu_pkg::OP_EQ, '1, '1);
		send_item(ialu_pkg::OP_NE, 64'd0, '1);
		send_item(ialu_pkg::OP_GT, '1, 64'd0);
		send_item(ialu_pkg::OP_GE, 64'd5, 64'd5);
		send_item(ialu_pkg::OP_LT, 64'd0, '1);
		send_item(ialu_pkg::OP_LE, '1, 64'd0);
		send_item(ialu_pkg::OP_AND, '1, 64'hA5A5_5A5A_F0F0_0F0F);
		send_item(ialu_pkg::OP_OR, 64'd0, '1);
		send_item(ialu_pkg::OP_XOR, '1, 64'h1234_5678_9ABC_DEF0);
		send_item(ialu_pkg::OP_SHL, '1, 64'd63);
		send_item(ialu_pkg::OP_SHL, '1, 64'd64);
		send_item(ialu_pkg::OP_SHR, '1, '1);
		send_item(ialu_pkg::OP_INC, '1, 64'd0);
		send_item(ialu_pkg::OP_DEC, 64'd0, '1);
		send_item(ialu_pkg::OP_NOT, 64'd0, 64'd0);
		send_item(ialu_pkg::OP_LNOT, 64'd0, 64'd1);
		send_item(ialu_pkg::OP_LTEST, '1, 64'd0);
		send_item(5'd31, '1, '1);
		wait_drain();
	endtask

	task automatic test_random(int n);
		logic [4:0] op;
		logic [63:0] b;
		repeat (n) begin
			op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 22)) :
				5'($urandom_range(21));
			b = rand_operand();
			if (op == ialu_pkg::OP_SHL || op == ialu_pkg::OP_SHR) begin
				if ($urandom_range(1)) b = 64'($urandom_range(70));
			end else if (op == ialu_pkg::OP_POW) begin
				if ($urandom_range(3) != 0) b = 64'($urandom_range(40));
			end
			send_item(op, rand_operand(), b);
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		recv_hold = 300;
		send_idle_pct = 0;
		repeat (12) send_item(5'($urandom_range(1)), rand_operand(), rand_operand());
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		in_item = '0;
		fail_count = 0;
		recv_hold = 0;
		send_idle_pct = 21;
		recv_idle_pct = 48;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(650);
		send_idle_pct = 48;
		recv_idle_pct = 21;
		test_random(650);
		test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(650);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: integer_alu_64_top.f
src/ialu_pkg.sv
src/ialu_front.sv
src/ialu_queue.sv
src/ialu_back.sv
src/integer_alu_64_top.sv
verif/integer_alu_64_top_tb.sv
